/* hw/rtl/ksa_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksa_pkg
// Shared types and constants for the keyed slot allocator: the request and
// response payloads, the stored slot entry and the operation codes.
// -----------------------------------------------------------------------------
package ksa_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam int SLOT_INDEX_W  = 5;
   localparam int KEY_W         = 16;
   localparam int TIME_W        = 32;
   localparam int LIFE_W        = 16;
   localparam int RADIUS_W      = 16;
   localparam int DECAY_W       = 16;
   localparam int LTYPE_W       = 4;
   localparam int ELAPSED_W     = 16;
   localparam int PRODUCT_W     = ELAPSED_W + DECAY_W;
   localparam int DECAY_SHIFT   = 10;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_DECAY = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [KEY_W-1:0]     key;
      logic [TIME_W-1:0]    now_time;
      logic [LIFE_W-1:0]    life_time;
      logic [RADIUS_W-1:0]  radius_in;
      logic [DECAY_W-1:0]   decay_rate;
      logic [LTYPE_W-1:0]   light_type;
      logic [ELAPSED_W-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    key_matched;
      logic                    forced_slot_zero;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TIME_W-1:0]   expiry;
      logic [RADIUS_W-1:0] radius;
      logic [DECAY_W-1:0]  decay;
      logic [LTYPE_W-1:0]  light_type;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

/* hw/rtl/ksa_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksa_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module ksa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ksa_store.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksa_store
// Slot table: one RAM word per slot plus a valid bit per slot. A slot never
// written since reset reads as an all-zero entry.
// -----------------------------------------------------------------------------
module ksa_store #(
   parameter int SLOTS = ksa_pkg::SLOTS_DEFAULT,
   localparam int AW = $clog2(SLOTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output ksa_pkg::slot_entry_type rd_entry,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  ksa_pkg::slot_entry_type wr_entry
);
   import ksa_pkg::*;

   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   valid_in;
   logic               rd_valid_ff;
   logic               rd_valid_in;
   logic [ENTRY_W-1:0] ram_q;

   ksa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ksa_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_entry = rd_valid_ff ? slot_entry_type'(ram_q) : '0;

endmodule

/* hw/rtl/keyed_slot_allocator_with_expiry_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// keyed_slot_allocator_with_expiry_core
// Sequence: each accepted request reads every slot in ascending order through
//   the single read port of the table, then loads the response register.
// Requests: a new request is taken only after the previous one has
//   finished, even while the previous response still waits in the output
//   register, and its finish step holds until that response is taken.
// Reset: synchronous; clears the sequencer, the response valid flag and the
//   per-slot valid bits, so the whole table reads as zero at once.
// -----------------------------------------------------------------------------
module keyed_slot_allocator_with_expiry_core #(
   parameter int SLOTS = ksa_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ksa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksa_pkg::rsp_type rsp_data
);
   import ksa_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Sequencer and per-request registers
   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   req_type       req_ff, req_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          match_found_ff, match_found_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic          exp_found_ff, exp_found_in;
   logic [AW-1:0] exp_idx_ff, exp_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Table access
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   slot_entry_type rd_entry;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   slot_entry_type wr_entry;

   // Per-slot evaluation of the word just read
   logic                       key_hit;
   logic                       expired;
   logic                       live;
   logic [PRODUCT_W-1:0]       product;
   logic [PRODUCT_W-DECAY_SHIFT-1:0] drop;
   logic [RADIUS_W-1:0]        new_radius;
   slot_entry_type             decayed;

   // Allocation result
   logic                finish_go;
   logic [AW-1:0]       pick;
   logic [TIME_W:0]     expiry_sum;
   slot_entry_type      alloc_entry;

   ksa_store #(
      .SLOTS (SLOTS)
   ) u_ksa_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   // Issue one read per scan cycle, slot by slot in ascending order.
   assign rd_en   = (state_ff == ST_SCAN) && (cnt_ff != CW'(SLOTS));
   assign rd_addr = cnt_ff[AW-1:0];

   // Evaluate the slot read in the previous cycle. A key of zero never hits.
   assign key_hit = (req_ff.key != '0) && (rd_entry.key == req_ff.key);
   assign expired = rd_entry.expiry < req_ff.now_time;
   assign live    = !expired && (rd_entry.radius != '0);

   // Shrink the radius by (elapsed * decay) >> 10 and clamp at zero.
   assign product    = {{DECAY_W{1'b0}}, req_ff.elapsed} * {{ELAPSED_W{1'b0}}, rd_entry.decay};
   assign drop       = product[PRODUCT_W-1:DECAY_SHIFT];
   assign new_radius = (drop >= (PRODUCT_W-DECAY_SHIFT)'(rd_entry.radius)) ?
                       '0 : rd_entry.radius - drop[RADIUS_W-1:0];

   always_comb begin
      decayed        = rd_entry;
      decayed.radius = new_radius;
   end

   // Pick: lowest key match, else lowest expired slot, else evict slot 0.
   assign pick = match_found_ff ? match_idx_ff :
                 exp_found_ff   ? exp_idx_ff   : '0;

   // Saturate the expiry time at its maximum.
   assign expiry_sum = {1'b0, req_ff.now_time} + (TIME_W + 1)'(req_ff.life_time);

   always_comb begin
      alloc_entry.key        = req_ff.key;
      alloc_entry.expiry     = expiry_sum[TIME_W] ? '1 : expiry_sum[TIME_W-1:0];
      alloc_entry.radius     = req_ff.radius_in;
      alloc_entry.decay      = req_ff.decay_rate;
      alloc_entry.light_type = req_ff.light_type;
   end

   // Finish once the response register is free or is being drained.
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Write port: decay writes back slot i while slot i+1 is being read, so a
   // read and a write never meet on one slot; allocate writes only after the
   // scan has drained.
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = rd_idx_ff;
      wr_entry = decayed;
      if (rd_pend_ff && (req_ff.operation == OP_DECAY) && live) begin
         wr_en = 1'b1;
      end else if (finish_go && (req_ff.operation == OP_ALLOC)) begin
         wr_en    = 1'b1;
         wr_addr  = pick;
         wr_entry = alloc_entry;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      req_in         = req_ff;
      rd_pend_in     = rd_en;
      rd_idx_in      = rd_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      exp_found_in   = exp_found_ff;
      exp_idx_in     = exp_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      // Drop the response once it is taken; a new one may load below.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (rd_en) begin
         rd_idx_in = rd_addr;
      end

      // Track the first key match and the first expired slot.
      if (rd_pend_ff && (req_ff.operation == OP_ALLOC)) begin
         if (key_hit && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
         end
         if (expired && !exp_found_ff) begin
            exp_found_in = 1'b1;
            exp_idx_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in         = req_data;
               cnt_in         = '0;
               match_found_in = 1'b0;
               exp_found_in   = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in = cnt_ff + CW'(1);
            end else begin
               // Last slot is evaluated in this cycle.
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               if (req_ff.operation == OP_ALLOC) begin
                  rsp_in.slot_index       = SLOT_INDEX_W'(pick);
                  rsp_in.key_matched      = match_found_ff;
                  rsp_in.forced_slot_zero = !match_found_ff && !exp_found_ff;
               end else begin
                  rsp_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rd_pend_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         exp_found_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rd_pend_ff     <= rd_pend_in;
         match_found_ff <= match_found_in;
         exp_found_ff   <= exp_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rd_idx_ff    <= rd_idx_in;
      match_idx_ff <= match_idx_in;
      exp_idx_ff   <= exp_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/ksa_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksa_checker
// Port-level checks on the slot allocator, bound to the top level.
// -----------------------------------------------------------------------------
module ksa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ksa_pkg::rsp_type rsp_data
);
   import ksa_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Count requests taken whose response is not yet delivered.
   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_forced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.forced_slot_zero |->
         rsp_data.slot_index == '0 && !rsp_data.key_matched)
      else $error("forced eviction must report slot 0 without match");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while previous one still scanning");

endmodule

bind keyed_slot_allocator_with_expiry_core ksa_checker u_ksa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/tb_keyed_slot_allocator_with_expiry_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_keyed_slot_allocator_with_expiry_core
// Drives allocate and decay requests into the slot table and predicts each
// response from a private copy of the table. Responses are checked in order,
// field by field. Both channels idle at random, apart from idle-free runs.
// -----------------------------------------------------------------------------
module tb_keyed_slot_allocator_with_expiry_core;
   import ksa_pkg::*;

   localparam int SLOTS            = SLOTS_DEFAULT;
   localparam int LATENCY          = SLOTS + 2;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int KEY_POOL_SIZE    = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Private copy of the table, updated as each request is accepted.
   slot_entry_type slot_table [SLOTS];
   // Predicted responses, oldest first.
   rsp_type        expected_slot_picks [$];

   int fail_count   = 0;
   int alloc_sent   = 0;
   int decay_sent   = 0;
   int rsp_seen     = 0;
   int matched_seen = 0;
   int forced_seen  = 0;
   int idle_cycles  = 0;
   int stall_left   = 0;
   bit sender_idles;
   bit receiver_stalls;

   keyed_slot_allocator_with_expiry_core #(
      .SLOTS(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Apply one request to the private table and return the response it yields.
   function automatic rsp_type advance_slot_table(req_type r);
      rsp_type              result;
      int                   pick;
      logic [TIME_W:0]      sum;
      logic [PRODUCT_W-1:0] drop;
      result = '0;
      if (r.operation == OP_DECAY) begin
         // Shrink every live entry; an entry past its expiry stays put.
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_table[i].expiry >= r.now_time && slot_table[i].radius != '0) begin
               drop = (PRODUCT_W'(r.elapsed) * PRODUCT_W'(slot_table[i].decay)) >> DECAY_SHIFT;
               if (drop >= PRODUCT_W'(slot_table[i].radius)) begin
                  slot_table[i].radius = '0;
               end else begin
                  slot_table[i].radius = slot_table[i].radius - drop[RADIUS_W-1:0];
               end
            end
         end
         return result;
      end
      pick = -1;
      // A zero key never matches, not even an empty slot.
      if (r.key != '0) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (pick < 0 && slot_table[i].key == r.key) begin
               pick = i;
               result.key_matched = 1'b1;
            end
         end
      end
      // Expiry equal to now still counts as live.
      if (pick < 0) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (pick < 0 && slot_table[i].expiry < r.now_time) begin
               pick = i;
            end
         end
      end
      if (pick < 0) begin
         pick = 0;
         result.forced_slot_zero = 1'b1;
      end
      sum = {1'b0, r.now_time} + (TIME_W + 1)'(r.life_time);
      slot_table[pick].key        = r.key;
      slot_table[pick].expiry     = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      slot_table[pick].radius     = r.radius_in;
      slot_table[pick].decay      = r.decay_rate;
      slot_table[pick].light_type = r.light_type;
      result.slot_index = SLOT_INDEX_W'(pick);
      return result;
   endfunction

   function automatic req_type make_request(logic op, logic [KEY_W-1:0] key,
                                            logic [TIME_W-1:0] now,
                                            logic [LIFE_W-1:0] life,
                                            logic [RADIUS_W-1:0] radius,
                                            logic [DECAY_W-1:0] decay,
                                            logic [LTYPE_W-1:0] ltype,
                                            logic [ELAPSED_W-1:0] elapsed);
      req_type r;
      r.operation  = op;
      r.key        = key;
      r.now_time   = now;
      r.life_time  = life;
      r.radius_in  = radius;
      r.decay_rate = decay;
      r.light_type = ltype;
      r.elapsed    = elapsed;
      return r;
   endfunction

   // Allocate with random payload; the ignored elapsed field is random too.
   function automatic req_type random_alloc(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now,
                                            logic [LIFE_W-1:0] life);
      return make_request(OP_ALLOC, key, now, life, RADIUS_W'($urandom), DECAY_W'($urandom),
                          LTYPE_W'($urandom), ELAPSED_W'($urandom));
   endfunction

   // Decay with random content in every field it ignores.
   function automatic req_type random_decay(logic [TIME_W-1:0] now,
                                            logic [ELAPSED_W-1:0] elapsed);
      return make_request(OP_DECAY, KEY_W'($urandom), now, LIFE_W'($urandom),
                          RADIUS_W'($urandom), DECAY_W'($urandom), LTYPE_W'($urandom),
                          elapsed);
   endfunction

   // Present one request and hold it until accepted. Keep valid high when no
   // gap follows so valid never drops and rises in the same step.
   task automatic send_request(input req_type r);
      int gap;
      gap = sender_idles ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_slot_picks.push_back(advance_slot_table(r));
      if (r.operation == OP_ALLOC) begin
         alloc_sent++;
      end else begin
         decay_sent++;
      end
   endtask

   // Stall the response side at random; hold ready low while a stall runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
         stall_left <= random_gap();
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_slot_picks.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES) begin
               $display("response with nothing pending: slot %0d match %0b forced %0b",
                        rsp_data.slot_index, rsp_data.key_matched, rsp_data.forced_slot_zero);
            end
         end else begin
            want = expected_slot_picks.pop_front();
            if (want.key_matched) begin
               matched_seen++;
            end
            if (want.forced_slot_zero) begin
               forced_seen++;
            end
            if (rsp_data.slot_index !== want.slot_index ||
                rsp_data.key_matched !== want.key_matched ||
                rsp_data.forced_slot_zero !== want.forced_slot_zero) begin
               fail_count++;
               if (fail_count <= SHOWN_MISMATCHES) begin
                  $display("response %0d: expected slot %0d match %0b forced %0b",
                           rsp_seen, want.slot_index, want.key_matched,
                           want.forced_slot_zero);
                  $display("   got slot %0d match %0b forced %0b",
                           rsp_data.slot_index, rsp_data.key_matched,
                           rsp_data.forced_slot_zero);
               end
            end
         end
      end
   end

   // Count cycles with no handshake on either side; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("keyed_slot_allocator_with_expiry_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Corners: empty table at time zero, key zero, equal expiry, saturation,
   // extreme payloads and decay that clamps, drops exactly or does nothing.
   task automatic test_directed_corners();
      send_request(make_request(OP_ALLOC, 16'h0000, 32'h0, 16'h0000, 16'h0000, 16'h0000,
                                4'h0, 16'h0000));
      send_request(make_request(OP_ALLOC, 16'h0001, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                4'hF, 16'hFFFF));
      send_request(make_request(OP_ALLOC, 16'h0001, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                4'hF, 16'h0000));
      send_request(make_request(OP_ALLOC, 16'h0000, 32'h1, 16'h0000, 16'h0040, 16'h0400,
                                4'h3, 16'h0000));
      // slot 1 now expires exactly at now: not free
      send_request(make_request(OP_ALLOC, 16'h0000, 32'h1, 16'h0000, 16'h0040, 16'h0400,
                                4'h3, 16'h0000));
      send_request(make_request(OP_DECAY, 16'h0000, 32'h0, 16'h0000, 16'h0000, 16'h0000,
                                4'h0, 16'hFFFF));
      send_request(make_request(OP_DECAY, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 4'hF, 16'h0000));
      // expiry saturates
      send_request(make_request(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234,
                                16'h0400, 4'h7, 16'h0000));
      send_request(make_request(OP_ALLOC, 16'hFFFF, 32'h2, 16'h0010, 16'h1234, 16'h0400,
                                4'h7, 16'h0000));
      send_request(make_request(OP_ALLOC, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0001,
                                16'h0001, 4'h1, 16'h0000));
      send_request(make_request(OP_ALLOC, 16'hAAAA, 32'h5555_5555, 16'hAAAA, 16'h5555,
                                16'hAAAA, 4'hA, 16'h5555));
      send_request(make_request(OP_ALLOC, 16'h5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA,
                                16'h5555, 4'h5, 16'hAAAA));
      // one second of decay drops exactly the stored rate
      send_request(make_request(OP_DECAY, 16'h0000, 32'h5555_5555, 16'h0000, 16'h0000,
                                16'h0000, 4'h0, 16'h0400));
      send_request(make_request(OP_DECAY, 16'h0000, 32'h0, 16'h0000, 16'h0000, 16'h0000,
                                4'h0, 16'h0001));
      send_request(make_request(OP_ALLOC, 16'h0000, 32'h0, 16'h0100, 16'h0000, 16'h0000,
                                4'h0, 16'h0000));
   endtask

   // Fill the table with fresh keys until slot 0 is forced, then reuse keys
   // with decay steps mixed in. Run the middle round with no idling.
   task automatic test_fill_and_evict();
      logic [KEY_W-1:0]  key_base;
      logic [TIME_W-1:0] now;
      for (int round = 0; round < 3; round++) begin
         sender_idles    = (round != 1);
         receiver_stalls = (round != 1);
         key_base = KEY_W'($urandom_range(1, 65400));
         now      = TIME_W'(round + 1) << 28;
         for (int i = 0; i < SLOTS; i++) begin
            now += $urandom_range(0, 3);
            send_request(random_alloc(key_base + KEY_W'(i), now,
                                      LIFE_W'($urandom_range(16'h8000, 16'hFFFF))));
         end
         // every slot is live: new keys land on slot 0
         for (int i = SLOTS; i < SLOTS + 8; i++) begin
            send_request(random_alloc(key_base + KEY_W'(i), now, LIFE_W'($urandom)));
         end
         send_request(random_alloc('0, now, LIFE_W'($urandom)));
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_request(random_decay(now + $urandom_range(0, 100), ELAPSED_W'($urandom)));
            end else begin
               send_request(random_alloc(key_base + KEY_W'($urandom_range(0, SLOTS + 7)), now,
                                         LIFE_W'($urandom)));
            end
         end
      end
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Park entries near the top of time, wrap back to small times, then hand
   // the parked keys zero lifetimes so they age out again.
   task automatic test_saturation_and_wrap();
      for (int i = 0; i < 8; i++) begin
         send_request(random_alloc(16'hFFF0 + KEY_W'(i),
                                   32'hFFFF_0000 + TIME_W'($urandom_range(0, 16'hFFFF)),
                                   (i % 2 == 0) ? 16'hFFFF : LIFE_W'($urandom)));
      end
      send_request(random_decay(32'hFFFF_FFFF, 16'hFFFF));
      send_request(random_decay(32'hFFFF_0000, ELAPSED_W'($urandom)));
      for (int i = 0; i < 8; i++) begin
         send_request(random_alloc(KEY_W'($urandom_range(1, 16'hFFEF)),
                                   TIME_W'($urandom_range(0, 1000)), LIFE_W'($urandom)));
      end
      send_request(random_alloc('0, '0, LIFE_W'($urandom)));
      for (int i = 0; i < 8; i++) begin
         send_request(random_alloc(16'hFFF0 + KEY_W'(i), '0, '0));
      end
   endtask

   // Bulk traffic on an advancing clock: keys mostly from a small pool so
   // they get reused, short lifetimes so slots age out, a quarter decay steps,
   // a little out-of-order time, and bursts of fresh keys that fill the table.
   task automatic test_random_traffic(input int count);
      logic [KEY_W-1:0]  key_pool [KEY_POOL_SIZE];
      logic [TIME_W-1:0] now;
      logic [KEY_W-1:0]  key;
      logic [LIFE_W-1:0] life;
      int                roll;
      int                sent;
      int                next_burst;
      foreach (key_pool[i]) begin
         key_pool[i] = KEY_W'($urandom_range(1, 16'hFFEF));
      end
      now        = 32'h4000_0000;
      sent       = 0;
      next_burst = 200;
      while (sent < count) begin
         // no idling on either side for the first 60 of every 400 requests
         sender_idles    = (sent % 400) >= 60;
         receiver_stalls = (sent % 400) >= 60;
         if (sent >= next_burst) begin
            for (int j = 0; j < SLOTS + 4; j++) begin
               send_request(random_alloc(KEY_W'($urandom_range(1, 16'hFFFF)), now, 16'h2000));
            end
            sent       += SLOTS + 4;
            next_burst += 250;
         end else begin
            now += $urandom_range(0, 300);
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               send_request(random_decay(($urandom_range(0, 49) == 0) ? TIME_W'($urandom) : now,
                                         ($urandom_range(0, 1) == 0) ?
                                            ELAPSED_W'($urandom_range(0, 2048)) :
                                            ELAPSED_W'($urandom)));
            end else begin
               if (roll < 35) begin
                  key = '0;
               end else if (roll < 85) begin
                  key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
               end else begin
                  key = KEY_W'($urandom);
               end
               life = ($urandom_range(0, 3) == 0) ? LIFE_W'($urandom) :
                                                    LIFE_W'($urandom_range(0, 6000));
               send_request(random_alloc(key, ($urandom_range(0, 49) == 0) ?
                                                 TIME_W'($urandom) : now, life));
            end
            sent++;
         end
      end
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      foreach (slot_table[i]) begin
         slot_table[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_fill_and_evict();
      test_saturation_and_wrap();
      test_random_traffic(1480);

      // Drop valid, drain the pending responses, then watch for strays.
      req_valid <= 1'b0;
      while (expected_slot_picks.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      fail_count += expected_slot_picks.size();

      $display("covered %0d allocate and %0d decay requests, %0d key reuses, %0d slot 0 evictions",
               alloc_sent, decay_sent, matched_seen, forced_seen);
      $display("checked %0d responses, %0d failures", rsp_seen, fail_count);
      if (fail_count == 0) begin
         $display("keyed_slot_allocator_with_expiry_core verification clean");
      end else begin
         $display("keyed_slot_allocator_with_expiry_core verification failed");
      end
      $finish;
   end

endmodule
